// ===== design/stereo_level_meter_top_defines.svh =====
// Assertion macros used by the stereo level meter checker.
`ifndef STEREO_LEVEL_METER_TOP_DEFINES_SVH
`define STEREO_LEVEL_METER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SLM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("stereo level meter: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SLM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("stereo level meter: next-cycle check failed");

// Check that holds while reset is asserted.
`define SLM_ASSERT_RST(lbl, cons) \
  lbl: assert property (@(posedge clk_i) (!rst_ni) |-> (cons)) \
    else $error("stereo level meter: reset check failed");

`endif

// ===== design/slm_pkg.sv =====
// Shared constants, types and helper functions of the stereo level meter.
package slm_pkg;

  // The frame length must be a power of two.
  localparam int FRAME_SAMPLES = 1024;
  localparam int FRAME_SHIFT   = $clog2(FRAME_SAMPLES);
  localparam int CNT_W         = FRAME_SHIFT;

  localparam int SAMPLE_W   = 16;
  localparam int MAG_W      = SAMPLE_W + 1;
  localparam int SQ_W       = 2 * MAG_W;
  localparam int SUM_W      = 41;
  localparam int ROOT_IN_W  = 32;
  localparam int ROOT_W     = ROOT_IN_W / 2;
  localparam int REM_W      = ROOT_W + 2;
  localparam int ROOT_IT_W  = $clog2(ROOT_W);
  localparam int LEVEL_W    = 16;
  localparam int BAR_W      = 10;
  localparam int COLOR_W    = 6;
  localparam int GRAD_W     = 7;
  localparam int RISE_W     = 2 * LEVEL_W;
  localparam int BAR_PROD_W = LEVEL_W + BAR_W;
  localparam int COL_PROD_W = LEVEL_W + COLOR_W;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};
  localparam logic [LEVEL_W-1:0] RISE_Q16  = 16'd39322;
  localparam logic [LEVEL_W:0]   SLEW_Q16  = 17'd1638;
  localparam logic [MAG_W-1:0]   AMP_FULL  = 17'd32767;
  localparam logic [GRAD_W-1:0]  GRAD_MAX  = 7'd64;
  localparam logic [COLOR_W-1:0] COLOR_TOP = 6'd63;

  localparam logic               MODE_RST  = 1'b0;
  localparam logic [LEVEL_W-1:0] DECAY_RST = 16'd1311;
  localparam logic [GRAD_W-1:0]  GRAD_RST  = 7'd8;
  localparam logic [BAR_W-1:0]   WIDTH_RST = 10'd80;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE  = 2'd0,
    REG_DECAY = 2'd1,
    REG_GRAD  = 2'd2,
    REG_WIDTH = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic               peak_mode;
    logic [LEVEL_W-1:0] decay_step;
    logic [GRAD_W-1:0]  gradient_count;
    logic [BAR_W-1:0]   display_width;
  } cfg_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [BAR_W-1:0]   bar;
    logic [COLOR_W-1:0] color;
  } lane_res_t;

  // Scales an amplitude by 65536 / 32767 with saturation. Below full scale the
  // quotient is twice the amplitude plus one once the amplitude reaches half scale.
  function automatic logic [LEVEL_W-1:0] to_level(input logic [MAG_W-1:0] amp);
    logic [LEVEL_W-1:0] lvl;
    if (amp >= AMP_FULL) begin
      lvl = {LEVEL_W{1'b1}};
    end else begin
      lvl = {amp[LEVEL_W-2:0], amp[LEVEL_W-2]};
    end
    return lvl;
  endfunction

endpackage

// ===== design/slm_accum.sv =====
// Per-channel frame accumulator: magnitude, square, saturating sum and peak.
module slm_accum (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  take_i,
  input  logic                                  last_i,
  input  logic signed [slm_pkg::SAMPLE_W-1:0]   sample_i,
  output logic                                  done_o,
  output logic        [slm_pkg::SUM_W-1:0]      sum_o,
  output logic        [slm_pkg::MAG_W-1:0]      peak_o
);

  logic [slm_pkg::MAG_W-1:0]   ext;
  logic [slm_pkg::MAG_W-1:0]   mag;
  logic                        vld_q;
  logic                        last_q;
  logic [slm_pkg::MAG_W-1:0]   mag_q;
  logic [slm_pkg::SQ_W-1:0]    sq_q;
  logic [slm_pkg::SUM_W-1:0]   sum_q;
  logic [slm_pkg::MAG_W-1:0]   peak_q;
  logic [slm_pkg::SUM_W:0]     sum_wide;
  logic [slm_pkg::SUM_W-1:0]   sum_d;
  logic [slm_pkg::MAG_W-1:0]   peak_d;
  logic                        done_q;
  logic [slm_pkg::SUM_W-1:0]   sum_out_q;
  logic [slm_pkg::MAG_W-1:0]   peak_out_q;

  assign ext = {sample_i[slm_pkg::SAMPLE_W-1], sample_i};
  assign mag = sample_i[slm_pkg::SAMPLE_W-1] ? (~ext + slm_pkg::MAG_W'(1)) : ext;

  assign sum_wide = {1'b0, sum_q} + (slm_pkg::SUM_W + 1)'(sq_q);
  assign sum_d    = sum_wide[slm_pkg::SUM_W] ? slm_pkg::SUM_MAX
                                             : sum_wide[slm_pkg::SUM_W-1:0];
  assign peak_d   = (mag_q > peak_q) ? mag_q : peak_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= 1'b0;
      last_q <= 1'b0;
      done_q <= 1'b0;
      sum_q  <= '0;
      peak_q <= '0;
    end else begin
      vld_q  <= take_i;
      last_q <= take_i & last_i;
      done_q <= vld_q & last_q;
      if (vld_q) begin
        if (last_q) begin
          sum_q  <= '0;
          peak_q <= '0;
        end else begin
          sum_q  <= sum_d;
          peak_q <= peak_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i) begin
      mag_q <= mag;
      sq_q  <= mag * mag;
    end
    if (vld_q && last_q) begin
      sum_out_q  <= sum_d;
      peak_out_q <= peak_d;
    end
  end

  assign done_o = done_q;
  assign sum_o  = sum_out_q;
  assign peak_o = peak_out_q;

endmodule

// ===== design/slm_finish.sv =====
// Per-channel frame-end unit: RMS square root, level scaling, ballistics, bar, color.
module slm_finish (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic                          clear_i,
  input  logic [slm_pkg::SUM_W-1:0]     sum_i,
  input  logic [slm_pkg::MAG_W-1:0]     peak_i,
  input  slm_pkg::cfg_t                 cfg_i,
  output logic                          done_o,
  output slm_pkg::lane_res_t            res_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROOT,
    ST_LEVEL,
    ST_RISE,
    ST_SHOWN,
    ST_TINT,
    ST_COLOR
  } state_e;

  state_e                              state_q;
  logic [slm_pkg::ROOT_IN_W-1:0]       x_q;
  logic [slm_pkg::REM_W-1:0]           rem_q;
  logic [slm_pkg::ROOT_W-1:0]          root_q;
  logic [slm_pkg::ROOT_IT_W-1:0]       it_q;
  logic [slm_pkg::MAG_W-1:0]           amp_q;
  logic [slm_pkg::LEVEL_W-1:0]         cur_q;
  logic                                up_q;
  logic [slm_pkg::RISE_W-1:0]          rise_prod_q;
  logic [slm_pkg::LEVEL_W-1:0]         shown_q;
  logic [slm_pkg::LEVEL_W-1:0]         tint_q;
  logic [slm_pkg::BAR_PROD_W-1:0]      bar_prod_q;
  logic [slm_pkg::BAR_W-1:0]           bar_q;
  logic [slm_pkg::COL_PROD_W-1:0]      color_prod_q;
  logic                                done_q;

  logic [slm_pkg::SUM_W-1:0]           mean;
  logic [slm_pkg::REM_W-1:0]           rem_try;
  logic [slm_pkg::REM_W-1:0]           trial;
  logic                                root_bit;
  logic [slm_pkg::REM_W-1:0]           rem_d;
  logic [slm_pkg::ROOT_W-1:0]          root_d;
  logic [slm_pkg::LEVEL_W-1:0]         fall;
  logic [slm_pkg::LEVEL_W:0]           s_ext;
  logic [slm_pkg::LEVEL_W:0]           t_ext;
  logic [slm_pkg::LEVEL_W:0]           tint_d;
  logic [slm_pkg::COLOR_W-1:0]         grad_mul;
  logic [slm_pkg::BAR_W-1:0]           bar_raw;

  assign mean = sum_i >> slm_pkg::FRAME_SHIFT;

  // One result bit per cycle of the restoring square root.
  assign rem_try  = {rem_q[slm_pkg::REM_W-3:0], x_q[slm_pkg::ROOT_IN_W-1 -: 2]};
  assign trial    = {root_q, 2'b01};
  assign root_bit = (rem_try >= trial);
  assign rem_d    = root_bit ? (rem_try - trial) : rem_try;
  assign root_d   = {root_q[slm_pkg::ROOT_W-2:0], root_bit};

  assign fall = (shown_q > cfg_i.decay_step) ? (shown_q - cfg_i.decay_step) : '0;

  assign s_ext = {1'b0, shown_q};
  assign t_ext = {1'b0, tint_q};

  always_comb begin
    if (s_ext > t_ext) begin
      tint_d = ((t_ext + slm_pkg::SLEW_Q16) < s_ext) ? (t_ext + slm_pkg::SLEW_Q16) : s_ext;
    end else begin
      tint_d = (t_ext > (s_ext + slm_pkg::SLEW_Q16)) ? (t_ext - slm_pkg::SLEW_Q16) : s_ext;
    end
  end

  always_comb begin
    if (cfg_i.gradient_count == '0) begin
      grad_mul = '0;
    end else if (cfg_i.gradient_count > slm_pkg::GRAD_MAX) begin
      grad_mul = slm_pkg::COLOR_TOP;
    end else begin
      grad_mul = slm_pkg::COLOR_W'(cfg_i.gradient_count - slm_pkg::GRAD_W'(1));
    end
  end

  assign bar_raw = bar_prod_q[slm_pkg::BAR_PROD_W-1:slm_pkg::LEVEL_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      x_q          <= '0;
      rem_q        <= '0;
      root_q       <= '0;
      it_q         <= '0;
      amp_q        <= '0;
      cur_q        <= '0;
      up_q         <= 1'b0;
      rise_prod_q  <= '0;
      shown_q      <= '0;
      tint_q       <= '0;
      bar_prod_q   <= '0;
      bar_q        <= '0;
      color_prod_q <= '0;
      done_q       <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            x_q    <= mean[slm_pkg::ROOT_IN_W-1:0];
            rem_q  <= '0;
            root_q <= '0;
            it_q   <= {slm_pkg::ROOT_IT_W{1'b1}};
            amp_q  <= peak_i;
            if (clear_i) begin
              shown_q <= '0;
              tint_q  <= '0;
            end
            state_q <= cfg_i.peak_mode ? ST_LEVEL : ST_ROOT;
          end
        end
        ST_ROOT: begin
          x_q    <= {x_q[slm_pkg::ROOT_IN_W-3:0], 2'b00};
          rem_q  <= rem_d;
          root_q <= root_d;
          it_q   <= it_q - slm_pkg::ROOT_IT_W'(1);
          if (it_q == '0) begin
            amp_q   <= {1'b0, root_d};
            state_q <= ST_LEVEL;
          end
        end
        ST_LEVEL: begin
          cur_q   <= slm_pkg::to_level(amp_q);
          state_q <= ST_RISE;
        end
        ST_RISE: begin
          up_q        <= (cur_q > shown_q);
          rise_prod_q <= (cur_q - shown_q) * slm_pkg::RISE_Q16;
          state_q     <= ST_SHOWN;
        end
        ST_SHOWN: begin
          shown_q <= up_q ? (shown_q + rise_prod_q[slm_pkg::RISE_W-1:slm_pkg::LEVEL_W])
                          : fall;
          state_q <= ST_TINT;
        end
        ST_TINT: begin
          tint_q     <= tint_d[slm_pkg::LEVEL_W-1:0];
          bar_prod_q <= shown_q * cfg_i.display_width;
          state_q    <= ST_COLOR;
        end
        ST_COLOR: begin
          color_prod_q <= tint_q * grad_mul;
          bar_q        <= (bar_raw > cfg_i.display_width) ? cfg_i.display_width : bar_raw;
          done_q       <= 1'b1;
          state_q      <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign done_o      = done_q;
  assign res_o.level = shown_q;
  assign res_o.bar   = bar_q;
  assign res_o.color = color_prod_q[slm_pkg::COL_PROD_W-1:slm_pkg::LEVEL_W];

endmodule

// ===== design/stereo_level_meter_top.sv =====
// Top level of the stereo level meter: config registers, frame control and result register.
// Throughput: one stereo sample per cycle; a frame's last sample waits only while the
// previous frame's result is still in flight or not yet taken.
// In RMS mode a frame's result passes the 16-step square root before the level steps;
// in peak mode the square root is skipped.
// Reset clears shown levels, accumulators and handshake state and loads the default config.
module stereo_level_meter_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic        [slm_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic        [slm_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [slm_pkg::SAMPLE_W-1:0]  left_sample_i,
  input  logic signed [slm_pkg::SAMPLE_W-1:0]  right_sample_i,
  input  logic                                 audio_present_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic        [slm_pkg::LEVEL_W-1:0]   left_level_o,
  output logic        [slm_pkg::LEVEL_W-1:0]   right_level_o,
  output logic        [slm_pkg::BAR_W-1:0]     left_bar_o,
  output logic        [slm_pkg::BAR_W-1:0]     right_bar_o,
  output logic        [slm_pkg::COLOR_W-1:0]   left_color_o,
  output logic        [slm_pkg::COLOR_W-1:0]   right_color_o
);

  slm_pkg::cfg_t               cfg_q;
  logic [slm_pkg::CNT_W-1:0]   cnt_q;
  logic                        pend_q;
  logic                        pres_q;
  logic                        out_valid_q;
  slm_pkg::lane_res_t          out_l_q;
  slm_pkg::lane_res_t          out_r_q;

  logic                        last;
  logic                        take;
  logic                        last_take;
  logic                        acc_done_l;
  logic                        acc_done_r;
  logic [slm_pkg::SUM_W-1:0]   sum_l;
  logic [slm_pkg::SUM_W-1:0]   sum_r;
  logic [slm_pkg::MAG_W-1:0]   peak_l;
  logic [slm_pkg::MAG_W-1:0]   peak_r;
  logic                        fin_done_l;
  logic                        fin_done_r;
  logic                        fin_done;
  slm_pkg::lane_res_t          res_l;
  slm_pkg::lane_res_t          res_r;

  assign last       = (cnt_q == slm_pkg::CNT_W'(slm_pkg::FRAME_SAMPLES - 1));
  assign in_ready_o = !(last && (pend_q || out_valid_q));
  assign take       = in_valid_i && in_ready_o;
  assign last_take  = take && last;
  assign fin_done   = fin_done_l && fin_done_r;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.peak_mode      <= slm_pkg::MODE_RST;
      cfg_q.decay_step     <= slm_pkg::DECAY_RST;
      cfg_q.gradient_count <= slm_pkg::GRAD_RST;
      cfg_q.display_width  <= slm_pkg::WIDTH_RST;
    end else if (cfg_we_i) begin
      unique case (slm_pkg::cfg_reg_e'(cfg_idx_i))
        slm_pkg::REG_MODE:  cfg_q.peak_mode      <= cfg_wdata_i[0];
        slm_pkg::REG_DECAY: cfg_q.decay_step     <= cfg_wdata_i[slm_pkg::LEVEL_W-1:0];
        slm_pkg::REG_GRAD:  cfg_q.gradient_count <= cfg_wdata_i[slm_pkg::GRAD_W-1:0];
        slm_pkg::REG_WIDTH: cfg_q.display_width  <= cfg_wdata_i[slm_pkg::BAR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      pres_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        cnt_q <= last ? '0 : (cnt_q + slm_pkg::CNT_W'(1));
      end
      if (last_take) begin
        pres_q <= audio_present_i;
      end
      if (fin_done) begin
        pend_q      <= 1'b0;
        out_valid_q <= 1'b1;
      end else begin
        if (last_take) begin
          pend_q <= 1'b1;
        end
        if (out_ready_i) begin
          out_valid_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_done) begin
      out_l_q <= res_l;
      out_r_q <= res_r;
    end
  end

  slm_accum u_accum_l (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .take_i   (take),
    .last_i   (last),
    .sample_i (left_sample_i),
    .done_o   (acc_done_l),
    .sum_o    (sum_l),
    .peak_o   (peak_l)
  );

  slm_accum u_accum_r (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .take_i   (take),
    .last_i   (last),
    .sample_i (right_sample_i),
    .done_o   (acc_done_r),
    .sum_o    (sum_r),
    .peak_o   (peak_r)
  );

  slm_finish u_finish_l (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (acc_done_l),
    .clear_i (!pres_q),
    .sum_i   (sum_l),
    .peak_i  (peak_l),
    .cfg_i   (cfg_q),
    .done_o  (fin_done_l),
    .res_o   (res_l)
  );

  slm_finish u_finish_r (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (acc_done_r),
    .clear_i (!pres_q),
    .sum_i   (sum_r),
    .peak_i  (peak_r),
    .cfg_i   (cfg_q),
    .done_o  (fin_done_r),
    .res_o   (res_r)
  );

  assign out_valid_o   = out_valid_q;
  assign left_level_o  = out_l_q.level;
  assign right_level_o = out_r_q.level;
  assign left_bar_o    = out_l_q.bar;
  assign right_bar_o   = out_r_q.bar;
  assign left_color_o  = out_l_q.color;
  assign right_color_o = out_r_q.color;

endmodule

// ===== design/slm_checker.sv =====
// Port-level checker for the stereo level meter and its bind to the top level.
`include "stereo_level_meter_top_defines.svh"

module slm_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic                          in_ready_o,
  input logic [slm_pkg::LEVEL_W-1:0]   left_level_o,
  input logic [slm_pkg::LEVEL_W-1:0]   right_level_o,
  input logic [slm_pkg::BAR_W-1:0]     left_bar_o,
  input logic [slm_pkg::BAR_W-1:0]     right_bar_o
);

  // A waiting result holds its value until it is taken.
  `SLM_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(left_level_o) && $stable(right_level_o) && $stable(left_bar_o) && $stable(right_bar_o))

  // Frames are at least several samples apart, so a taken result is never followed at once.
  `SLM_ASSERT_NEXT(a_out_gap, out_valid_o && out_ready_i, !out_valid_o)

  // The input side only stalls on a frame end, which cannot happen right after a result.
  `SLM_ASSERT_NOW(a_ready_after_take, $past(out_valid_o && out_ready_i), in_ready_o)

  // Reset leaves no result pending and the input open.
  `SLM_ASSERT_RST(a_reset_idle, !out_valid_o && in_ready_o)

endmodule

bind stereo_level_meter_top slm_checker u_slm_checker (.*);

// ===== verif/tb_stereo_level_meter_top.sv =====
// Self-checking testbench for the stereo level meter: frame stimulus, level prediction, result checks.
`timescale 1ns / 100ps

module tb_stereo_level_meter_top;
  import slm_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASES = 11;
  localparam int FRAMES_PER_PHASE = 4;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES = 4000;
  localparam int HEAD_LEN = 12;

  localparam logic signed [SAMPLE_W-1:0] HEAD_LEFT [HEAD_LEN] = '{
    16'sd32767, -16'sd32768, 16'sd0, -16'sd1, 16'sd1, 16'sd16384,
    16'sd16383, -16'sd16384, 16'sh5555, 16'shAAAA, 16'sd32767, -16'sd32768};
  localparam logic signed [SAMPLE_W-1:0] HEAD_RIGHT [HEAD_LEN] = '{
    -16'sd32768, 16'sd32767, 16'sd0, 16'sd1, -16'sd1, -16'sd16384,
    -16'sd16383, 16'sd16384, 16'shAAAA, 16'sh5555, -16'sd32768, 16'sd32767};

  typedef enum int {STYLE_QUIET, STYLE_FULL, STYLE_SCALED, STYLE_NOISE} frame_style_e;

  typedef struct packed {
    logic [LEVEL_W-1:0] left_level;
    logic [LEVEL_W-1:0] right_level;
    logic [BAR_W-1:0]   left_bar;
    logic [BAR_W-1:0]   right_bar;
    logic [COLOR_W-1:0] left_color;
    logic [COLOR_W-1:0] right_color;
  } meter_reading_t;

  class meter_tracker;
    logic               peak_mode;
    logic [LEVEL_W-1:0] decay_step;
    logic [GRAD_W-1:0]  gradient_count;
    logic [BAR_W-1:0]   display_width;
    int unsigned        samples_seen;
    longint unsigned    left_sq, right_sq;
    longint unsigned    left_pk, right_pk;
    longint unsigned    left_shown, right_shown, left_tint, right_tint;
    meter_reading_t     readings_due[$];
    int                 mismatch_count;

    function new();
      peak_mode = MODE_RST;
      decay_step = DECAY_RST;
      gradient_count = GRAD_RST;
      display_width = WIDTH_RST;
      samples_seen = 0;
      left_sq = 0;
      right_sq = 0;
      left_pk = 0;
      right_pk = 0;
      left_shown = 0;
      right_shown = 0;
      left_tint = 0;
      right_tint = 0;
      mismatch_count = 0;
    endfunction

    function void set_register(cfg_reg_e idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_MODE: peak_mode = val[0];
        REG_DECAY: decay_step = val[LEVEL_W-1:0];
        REG_GRAD: gradient_count = val[GRAD_W-1:0];
        REG_WIDTH: display_width = val[BAR_W-1:0];
        default: ;
      endcase
    endfunction

    function longint unsigned amp_of(logic signed [SAMPLE_W-1:0] s);
      longint v;
      v = s;
      return (v < 0) ? -v : v;
    endfunction

    function longint unsigned add_square(longint unsigned sum, longint unsigned amp);
      longint unsigned total;
      total = sum + amp * amp;
      return (total > SUM_MAX) ? SUM_MAX : total;
    endfunction

    function longint unsigned level_for(longint unsigned sum, longint unsigned peak);
      longint unsigned mean, root, trial, amp, lvl;
      if (peak_mode) begin
        amp = peak;
      end else begin
        mean = sum / FRAME_SAMPLES;
        root = 0;
        for (int b = 16; b >= 0; b--) begin
          trial = root | (64'd1 << b);
          if (trial * trial <= mean) root = trial;
        end
        amp = root;
      end
      lvl = (amp << 16) / longint'(AMP_FULL);
      return (lvl > 65535) ? 65535 : lvl;
    endfunction

    function void follow(longint unsigned cur, ref longint unsigned shown,
                         ref longint unsigned tint);
      longint unsigned slew;
      slew = SLEW_Q16;
      if (cur > shown) begin
        shown += ((cur - shown) * RISE_Q16) >> 16;
      end else begin
        shown = (shown > decay_step) ? shown - decay_step : 0;
      end
      if (shown > tint) begin
        tint = (tint + slew < shown) ? tint + slew : shown;
      end else begin
        tint = (tint > shown + slew) ? tint - slew : shown;
      end
    endfunction

    function longint unsigned bar_of(longint unsigned lvl);
      longint unsigned b;
      b = (lvl * display_width) >> 16;
      return (b > display_width) ? display_width : b;
    endfunction

    function longint unsigned color_of(longint unsigned tint);
      longint unsigned n;
      n = (gradient_count > GRAD_MAX) ? GRAD_MAX : gradient_count;
      if (n == 0) return 0;
      return ((tint * (n - 1)) >> 16) & COLOR_TOP;
    endfunction

    function void take_sample(logic signed [SAMPLE_W-1:0] l, logic signed [SAMPLE_W-1:0] r,
                              logic present);
      longint unsigned lm, rm, lc, rc;
      meter_reading_t due;
      lm = amp_of(l);
      rm = amp_of(r);
      left_sq = add_square(left_sq, lm);
      right_sq = add_square(right_sq, rm);
      if (lm > left_pk) left_pk = lm;
      if (rm > right_pk) right_pk = rm;
      samples_seen++;
      if (samples_seen < FRAME_SAMPLES) return;
      if (!present) begin
        left_shown = 0;
        right_shown = 0;
        left_tint = 0;
        right_tint = 0;
      end
      lc = level_for(left_sq, left_pk);
      rc = level_for(right_sq, right_pk);
      follow(lc, left_shown, left_tint);
      follow(rc, right_shown, right_tint);
      due.left_level = LEVEL_W'(left_shown);
      due.right_level = LEVEL_W'(right_shown);
      due.left_bar = BAR_W'(bar_of(left_shown));
      due.right_bar = BAR_W'(bar_of(right_shown));
      due.left_color = COLOR_W'(color_of(left_tint));
      due.right_color = COLOR_W'(color_of(right_tint));
      readings_due = {readings_due, due};
      samples_seen = 0;
      left_sq = 0;
      right_sq = 0;
      left_pk = 0;
      right_pk = 0;
    endfunction

    function void compare_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        mismatch_count++;
      end
    endfunction

    function void check_reading(meter_reading_t got);
      meter_reading_t want;
      if (readings_due.size() == 0) begin
        $display("%0t: unexpected reading, expected none, actual %p", $time, got);
        mismatch_count++;
        return;
      end
      want = readings_due.pop_front();
      compare_field("left_level", want.left_level, got.left_level);
      compare_field("right_level", want.right_level, got.right_level);
      compare_field("left_bar", want.left_bar, got.left_bar);
      compare_field("right_bar", want.right_bar, got.right_bar);
      compare_field("left_color", want.left_color, got.left_color);
      compare_field("right_color", want.right_color, got.right_color);
    endfunction

    function int pending();
      return readings_due.size();
    endfunction
  endclass

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b1;
  logic                       cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0]      cfg_wdata_i = '0;
  logic                       in_valid_i = 1'b0;
  logic                       in_ready_o;
  logic signed [SAMPLE_W-1:0] left_sample_i = '0;
  logic signed [SAMPLE_W-1:0] right_sample_i = '0;
  logic                       audio_present_i = 1'b0;
  logic                       out_valid_o;
  logic                       out_ready_i = 1'b0;
  logic [LEVEL_W-1:0]         left_level_o, right_level_o;
  logic [BAR_W-1:0]           left_bar_o, right_bar_o;
  logic [COLOR_W-1:0]         left_color_o, right_color_o;

  meter_tracker tracker = new();
  int cycle_count = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int rx_hold_cycles = 0;
  int hold_left = 0;

  stereo_level_meter_top uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .left_sample_i  (left_sample_i),
    .right_sample_i (right_sample_i),
    .audio_present_i(audio_present_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .left_level_o   (left_level_o),
    .right_level_o  (right_level_o),
    .left_bar_o     (left_bar_o),
    .right_bar_o    (right_bar_o),
    .left_color_o   (left_color_o),
    .right_color_o  (right_color_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (hold_left == 0 && rx_hold_cycles != 0) begin
      hold_left = rx_hold_cycles;
      rx_hold_cycles = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= (rx_idle_pct == 0) || ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      tracker.check_reading(meter_reading_t'{left_level_o, right_level_o, left_bar_o,
                                             right_bar_o, left_color_o, right_color_o});
    end
  end

  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    tracker.set_register(idx, val);
    @(posedge clk_i);
  endtask

  task automatic set_config(logic mode, logic [LEVEL_W-1:0] decay, logic [GRAD_W-1:0] grad,
                            logic [BAR_W-1:0] width);
    write_reg(REG_MODE, CFG_DATA_W'(mode));
    write_reg(REG_DECAY, CFG_DATA_W'(decay));
    write_reg(REG_GRAD, CFG_DATA_W'(grad));
    write_reg(REG_WIDTH, CFG_DATA_W'(width));
    cfg_we_i <= 1'b0;
  endtask

  task automatic offer_sample(logic signed [SAMPLE_W-1:0] l, logic signed [SAMPLE_W-1:0] r,
                              logic present);
    while (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    left_sample_i <= l;
    right_sample_i <= r;
    audio_present_i <= present;
    do @(posedge clk_i); while (!in_ready_o);
    tracker.take_sample(l, r, present);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] draw_sample(frame_style_e style, int amp);
    int v;
    case (style)
      STYLE_QUIET: v = 0;
      STYLE_FULL: begin
        case ($urandom_range(0, 2))
          0: v = 32767;
          1: v = -32768;
          default: v = -32767;
        endcase
      end
      STYLE_NOISE: v = int'($urandom_range(0, 65535)) - 32768;
      default: begin
        v = int'($urandom_range(0, 2 * amp)) - amp;
        if ($urandom_range(0, 255) == 0) v = -32768;
        if (v > 32767) v = 32767;
      end
    endcase
    return v[SAMPLE_W-1:0];
  endfunction

  task automatic send_frame(frame_style_e style, int first, logic last_present);
    int amp_l, amp_r;
    logic present;
    amp_l = $urandom_range(0, 32768) >> $urandom_range(0, 15);
    amp_r = $urandom_range(0, 32768) >> $urandom_range(0, 15);
    for (int i = first; i < FRAME_SAMPLES; i++) begin
      present = (i == FRAME_SAMPLES - 1) ? last_present : 1'($urandom_range(0, 1));
      offer_sample(draw_sample(style, amp_l), draw_sample(style, amp_r), present);
    end
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    frame_style_e style;
    logic last_present;
    int first;
    rst_ni <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int p = 0; p < PHASES; p++) begin
      if (p < 4) begin
        tx_idle_pct = 29;
        rx_idle_pct = 71;
      end else if (p < 8) begin
        tx_idle_pct = 71;
        rx_idle_pct = 29;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      if (p > 0) begin
        settle();
        case (p)
          1: set_config(1'b1, 16'd0, 7'd64, 10'd1023);
          2: set_config(1'b0, 16'd65535, 7'd1, 10'd0);
          3: set_config(1'b1, DECAY_RST, 7'd0, 10'd1);
          4: set_config(1'b0, 16'($urandom_range(0, 4000)), 7'd127,
                        10'($urandom_range(0, 1023)));
          default: set_config(1'($urandom_range(0, 1)), 16'($urandom_range(0, 8191)),
                              7'($urandom_range(0, 127)), 10'($urandom_range(0, 1023)));
        endcase
      end
      if (p == 1) rx_hold_cycles = HOLD_CYCLES;
      for (int f = 0; f < FRAMES_PER_PHASE; f++) begin
        first = 0;
        if (p == 0) begin
          case (f)
            0: style = STYLE_SCALED;
            1: style = STYLE_FULL;
            2: style = STYLE_QUIET;
            default: style = STYLE_NOISE;
          endcase
        end else if (f == 0) begin
          style = STYLE_FULL;
        end else begin
          case ($urandom_range(0, 9))
            0: style = STYLE_QUIET;
            1: style = STYLE_FULL;
            2: style = STYLE_NOISE;
            default: style = STYLE_SCALED;
          endcase
        end
        last_present = (p == 0 && f == 2) ? 1'b0 : ($urandom_range(0, 4) != 0);
        if (p == 0 && f == 0) begin
          for (int i = 0; i < HEAD_LEN; i++) begin
            offer_sample(HEAD_LEFT[i], HEAD_RIGHT[i], 1'(i));
          end
          first = HEAD_LEN;
        end
        send_frame(style, first, last_present);
      end
    end
    settle();
    if (tracker.mismatch_count == 0 && tracker.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/slm_pkg.sv
design/slm_accum.sv
design/slm_finish.sv
design/stereo_level_meter_top.sv
design/slm_checker.sv
verif/tb_stereo_level_meter_top.sv
